@@ rtl/cmte_pkg.sv @@
package cmte_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int KERNEL_SIZE   = 3;
    localparam int WIN_BITS      = KERNEL_SIZE * KERNEL_SIZE;

    localparam int LEVEL_W       = 8;
    localparam int IN_TDATA_W    = 3 * LEVEL_W;
    localparam int OUT_TDATA_W   = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 12;
    localparam int FRAME_W_BITS  = 11;
    localparam int FRAME_H_BITS  = 12;
    // row counter also covers the two drain rows after the frame
    localparam int ROW_W         = FRAME_H_BITS + 1;

    localparam logic [LEVEL_W-1:0]      RESET_HL_THR_RED   = 8'd128;
    localparam logic [LEVEL_W-1:0]      RESET_THR_RED      = 8'd64;
    localparam logic [LEVEL_W-1:0]      RESET_THR_BLUE     = 8'd64;
    localparam int                      RESET_FRAME_WIDTH  = 640;
    localparam logic [FRAME_H_BITS-1:0] RESET_FRAME_HEIGHT = 12'd480;
    localparam int                      MIN_FRAME_WIDTH    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_MODE      = 3'd0,
        CFG_HL_THR_RED      = 3'd1,
        CFG_COLOR_THR_RED   = 3'd2,
        CFG_COLOR_THR_BLUE  = 3'd3,
        CFG_FRAME_WIDTH     = 3'd4,
        CFG_FRAME_HEIGHT    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               color_mode;
        logic [LEVEL_W-1:0] hl_thr_red;
        logic [LEVEL_W-1:0] thr_red;
        logic [LEVEL_W-1:0] thr_blue;
    } t_cfg;

    // per-word control carried from the front stage to the window stage
    typedef struct packed {
        logic is_pixel;
        logic row_par;
        logic t_bit;
        logic h_bit;
        logic res_a;      // last column of the row two above, before the shift
        logic res_b;      // ordinary result, after the shift
        logic top_ok;
        logic bot_ok;
        logic col_lo1;    // leftmost window column lies outside the frame
        logic frame_end;
        logic restart;
    } t_item;

    typedef struct packed {
        logic highlight;
        logic color;
        logic frame_end;
    } t_result;

    // and over the window columns in range and the valid rows
    function automatic logic erode_win(input logic [WIN_BITS-1:0] win,
                                       input logic col_lo1,
                                       input logic top_ok,
                                       input logic bot_ok);
        logic ok;
        ok = 1'b1;
        for (int col = 0; col < KERNEL_SIZE; col++) begin
            if (!(col == 0 && col_lo1)) begin
                if (!win[col*KERNEL_SIZE+1]) ok = 1'b0;
                if (top_ok && !win[col*KERNEL_SIZE]) ok = 1'b0;
                if (bot_ok && !win[col*KERNEL_SIZE+2]) ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

@@ rtl/cmte_front.sv @@
module cmte_front
    import cmte_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = CW + 1,
    localparam int PW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_restart,
    input  t_cfg                    i_cfg,
    input  logic [WW-1:0]           i_width,
    input  logic [FRAME_H_BITS-1:0] i_height,
    input  logic                    i_valid,
    input  logic                    i_flush,
    input  logic [LEVEL_W-1:0]      i_blue,
    input  logic [LEVEL_W-1:0]      i_green,
    input  logic [LEVEL_W-1:0]      i_red,
    input  logic                    i_s1_free,
    output logic                    o_ready,
    output logic                    o_load,
    output t_item                   o_item,
    output logic [CW-1:0]           o_col,
    output logic [PW-1:0]           o_ptr
);

    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PW-1:0]    r_ptr, n_ptr;

    logic [ROW_W-1:0] height_x;
    logic [ROW_W-1:0] height_p1;
    logic             is_pixel;
    logic             at_end;
    logic             accept;
    logic [WW-1:0]    col_inc;
    logic [LEVEL_W:0] diff_rb, diff_br;
    logic [LEVEL_W-1:0] d_rb, d_br, hl_thr;
    logic             t_bit, h_bit;
    logic             col0, row_ge2;

    assign height_x  = {1'b0, i_height};
    assign height_p1 = height_x + ROW_W'(1);
    assign is_pixel  = r_row < height_x;
    assign at_end    = r_row >= height_p1;

    assign o_ready = i_s1_free;
    assign accept  = i_valid && i_s1_free;
    // a flush inside the frame is taken and dropped
    assign o_load  = accept && !(is_pixel && i_flush);
    assign o_col   = r_col;
    assign o_ptr   = r_ptr;

    // saturating channel differences and thresholds
    always_comb begin
        diff_rb = {1'b0, i_red} - {1'b0, i_blue};
        diff_br = {1'b0, i_blue} - {1'b0, i_red};
        d_rb    = (i_red > i_blue) ? diff_rb[LEVEL_W-1:0] : '0;
        d_br    = (i_blue > i_red) ? diff_br[LEVEL_W-1:0] : '0;
        hl_thr  = i_cfg.color_mode ? i_cfg.thr_blue : i_cfg.hl_thr_red;
        t_bit   = i_cfg.color_mode ? (d_br > i_cfg.thr_blue) : (d_rb > i_cfg.thr_red);
        h_bit   = i_green > hl_thr;
    end

    always_comb begin
        col0    = r_col == '0;
        row_ge2 = r_row >= ROW_W'(2);
        o_item.is_pixel  = is_pixel;
        o_item.row_par   = r_row[0];
        o_item.t_bit     = is_pixel && t_bit;
        o_item.h_bit     = is_pixel && h_bit;
        o_item.res_a     = col0 && row_ge2;
        o_item.res_b     = !col0 && (r_row != '0);
        o_item.top_ok    = col0 ? (r_row >= ROW_W'(3)) : row_ge2;
        o_item.bot_ok    = col0 ? (r_row <= height_x) : is_pixel;
        o_item.col_lo1   = col0 || (r_col == CW'(1));
        o_item.frame_end = r_row == height_p1;
        o_item.restart   = at_end;
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_ptr   = r_ptr;
        col_inc = {1'b0, r_col} + WW'(1);
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
            n_ptr = '0;
        end else if (o_load) begin
            if (at_end) begin
                n_col = '0;
                n_row = '0;
                n_ptr = '0;
            end else begin
                n_ptr = (WW'(r_ptr) >= i_width) ? '0 : r_ptr + PW'(1);
                if (col_inc >= i_width) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                end else begin
                    n_col = col_inc[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ptr <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_ptr <= n_ptr;
        end
    end

endmodule

@@ rtl/cmte_stores.sv @@
module cmte_stores
    import cmte_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int PW = $clog2(MAX_WIDTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [CW-1:0] i_rd_col,
    input  logic [PW-1:0] i_rd_ptr,
    input  logic          i_line_we,
    input  logic [CW-1:0] i_line_wa,
    input  logic [1:0]    i_line_wd,
    input  logic          i_hl_we,
    input  logic [PW-1:0] i_hl_wa,
    input  logic          i_hl_wd,
    output logic [1:0]    o_line_rd,
    output logic          o_hl_rd
);

    // one entry per column, bit p holds the row of parity p
    logic [1:0] r_line_mem [MAX_WIDTH];
    logic       r_hl_mem [MAX_WIDTH + 1];
    logic [1:0] r_line_rd;
    logic       r_hl_rd;

    always_ff @(posedge i_clk) begin
        if (i_line_we) begin
            r_line_mem[i_line_wa] <= i_line_wd;
        end
        if (i_hl_we) begin
            r_hl_mem[i_hl_wa] <= i_hl_wd;
        end
    end

    // read data holds until the next read; forward a write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_line_rd <= (i_line_we && i_line_wa == i_rd_col) ? i_line_wd
                                                              : r_line_mem[i_rd_col];
            r_hl_rd   <= (i_hl_we && i_hl_wa == i_rd_ptr) ? i_hl_wd : r_hl_mem[i_rd_ptr];
        end
    end

    assign o_line_rd = r_line_rd;
    assign o_hl_rd   = r_hl_rd;

endmodule

@@ rtl/cmte_window.sv @@
module cmte_window
    import cmte_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int PW = $clog2(MAX_WIDTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_restart,
    input  logic          i_color_mode,
    input  logic          i_load,
    input  t_item         i_item,
    input  logic [CW-1:0] i_col,
    input  logic [PW-1:0] i_ptr,
    input  logic [1:0]    i_line_rd,
    input  logic          i_hl_rd,
    input  logic          i_space,
    output logic          o_s1_free,
    output logic          o_line_we,
    output logic [CW-1:0] o_line_wa,
    output logic [1:0]    o_line_wd,
    output logic          o_hl_we,
    output logic [PW-1:0] o_hl_wa,
    output logic          o_hl_wd,
    output logic          o_push,
    output t_result       o_result
);

    logic                r_valid;
    t_item               r_item;
    logic [CW-1:0]       r_col;
    logic [PW-1:0]       r_ptr;
    logic [WIN_BITS-1:0] r_win, n_win;

    logic fire;
    logic above2, above1;
    logic color_a, color_b;

    assign fire      = r_valid && i_space;
    assign o_s1_free = !r_valid || fire;

    always_comb begin
        above2 = r_item.row_par ? i_line_rd[1] : i_line_rd[0];
        above1 = r_item.row_par ? i_line_rd[0] : i_line_rd[1];
        n_win  = {r_item.t_bit, above1, above2, r_win[WIN_BITS-1:KERNEL_SIZE]};

        color_a = i_color_mode ? r_win[7]
                               : erode_win(r_win, r_item.col_lo1, r_item.top_ok,
                                           r_item.bot_ok);
        color_b = i_color_mode ? n_win[4]
                               : erode_win(n_win, r_item.col_lo1, r_item.top_ok,
                                           r_item.bot_ok);
    end

    // write back this row's bit into its parity slot
    assign o_line_we = fire && r_item.is_pixel;
    assign o_line_wa = r_col;
    assign o_line_wd = r_item.row_par ? {r_item.t_bit, i_line_rd[0]}
                                      : {i_line_rd[1], r_item.t_bit};
    assign o_hl_we   = fire && r_item.is_pixel;
    assign o_hl_wa   = r_ptr;
    assign o_hl_wd   = r_item.h_bit;

    assign o_push             = fire && (r_item.res_a || r_item.res_b);
    assign o_result.highlight = i_hl_rd;
    assign o_result.color     = r_item.res_a ? color_a : color_b;
    assign o_result.frame_end = r_item.res_a && r_item.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_win   <= '0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
            end else if (fire) begin
                r_valid <= 1'b0;
            end
            if (i_restart) begin
                r_win <= '0;
            end else if (fire) begin
                r_win <= r_item.restart ? '0 : n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
            r_col  <= i_col;
            r_ptr  <= i_ptr;
        end
    end

endmodule

@@ rtl/cmte_out_fifo.sv @@
module cmte_out_fifo
    import cmte_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result    r_buf [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_space  = r_cnt != 2'd2;
    assign o_valid  = r_cnt != 2'd0;
    assign o_result = r_buf[r_rd];
    assign pop      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_result;
        end
    end

endmodule

@@ rtl/color_mask_threshold_erode.sv @@
// latency: a pixel's word leaves frame_width+1 accepted words after it; the word that
// produces a result is registered in the window stage, then in the output buffer
// throughput: one word per cycle while not stalled, set by the line store read-modify-write
// reset: synchronous active low; counters, window and config go to defaults
// line stores are not cleared, an entry is always written before it is read
module color_mask_threshold_erode
    import cmte_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // blue_level, green_level, red_level
    input  logic                   i_s_axis_tuser,   // flush
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // highlight_bit, color_bit, zero fill
    output logic                   o_m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int RST_W = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;

    t_cfg                    r_cfg;
    logic [WW-1:0]           r_width;
    logic [FRAME_H_BITS-1:0] r_height;

    logic                    cfg_we;
    logic                    restart;
    logic [FRAME_W_BITS-1:0] wr_w;
    logic [WW-1:0]           clamp_w;

    logic          s1_free, load;
    t_item         item;
    logic [CW-1:0] rd_col;
    logic [PW-1:0] rd_ptr;
    logic          line_we, hl_we, hl_wd, hl_rd;
    logic [CW-1:0] line_wa;
    logic [PW-1:0] hl_wa;
    logic [1:0]    line_wd, line_rd;
    logic          space, push;
    t_result       result, out_result;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign restart     = cfg_we && (i_cfg_index == CFG_FRAME_WIDTH ||
                                    i_cfg_index == CFG_FRAME_HEIGHT);

    always_comb begin
        wr_w = i_cfg_data[FRAME_W_BITS-1:0];
        if (32'(wr_w) < 32'(MIN_FRAME_WIDTH)) begin
            clamp_w = WW'(MIN_FRAME_WIDTH);
        end else if (32'(wr_w) > 32'(MAX_WIDTH)) begin
            clamp_w = WW'(MAX_WIDTH);
        end else begin
            clamp_w = WW'(wr_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode <= 1'b0;
            r_cfg.hl_thr_red <= RESET_HL_THR_RED;
            r_cfg.thr_red    <= RESET_THR_RED;
            r_cfg.thr_blue   <= RESET_THR_BLUE;
            r_width          <= WW'(RST_W);
            r_height         <= RESET_FRAME_HEIGHT;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_COLOR_MODE:     r_cfg.color_mode <= i_cfg_data[0];
                CFG_HL_THR_RED:     r_cfg.hl_thr_red <= i_cfg_data[LEVEL_W-1:0];
                CFG_COLOR_THR_RED:  r_cfg.thr_red    <= i_cfg_data[LEVEL_W-1:0];
                CFG_COLOR_THR_BLUE: r_cfg.thr_blue   <= i_cfg_data[LEVEL_W-1:0];
                CFG_FRAME_WIDTH:    r_width          <= clamp_w;
                CFG_FRAME_HEIGHT: begin
                    // zero height acts as one row
                    r_height <= (i_cfg_data == '0) ? FRAME_H_BITS'(1)
                                                   : i_cfg_data[FRAME_H_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    cmte_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_cfg     (r_cfg),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_valid   (i_s_axis_tvalid),
        .i_flush   (i_s_axis_tuser),
        .i_blue    (i_s_axis_tdata[LEVEL_W-1:0]),
        .i_green   (i_s_axis_tdata[2*LEVEL_W-1:LEVEL_W]),
        .i_red     (i_s_axis_tdata[3*LEVEL_W-1:2*LEVEL_W]),
        .i_s1_free (s1_free),
        .o_ready   (o_s_axis_tready),
        .o_load    (load),
        .o_item    (item),
        .o_col     (rd_col),
        .o_ptr     (rd_ptr)
    );

    cmte_stores #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_stores (
        .i_clk     (i_clk),
        .i_rd_en   (load),
        .i_rd_col  (rd_col),
        .i_rd_ptr  (rd_ptr),
        .i_line_we (line_we),
        .i_line_wa (line_wa),
        .i_line_wd (line_wd),
        .i_hl_we   (hl_we),
        .i_hl_wa   (hl_wa),
        .i_hl_wd   (hl_wd),
        .o_line_rd (line_rd),
        .o_hl_rd   (hl_rd)
    );

    cmte_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_color_mode (r_cfg.color_mode),
        .i_load       (load),
        .i_item       (item),
        .i_col        (rd_col),
        .i_ptr        (rd_ptr),
        .i_line_rd    (line_rd),
        .i_hl_rd      (hl_rd),
        .i_space      (space),
        .o_s1_free    (s1_free),
        .o_line_we    (line_we),
        .o_line_wa    (line_wa),
        .o_line_wd    (line_wd),
        .o_hl_we      (hl_we),
        .o_hl_wa      (hl_wa),
        .o_hl_wd      (hl_wd),
        .o_push       (push),
        .o_result     (result)
    );

    cmte_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_space  (space),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W-2)'(0), out_result.color, out_result.highlight};
    assign o_m_axis_tlast = out_result.frame_end;

endmodule
